// ===== rtl/cwm_pkg.sv =====
// Shared types and constants for the centered window mean filter.
`timescale 1ns / 1ps

package cwm_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int RADIUS_W = 4;
	localparam int COUNT_W  = 16;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd2;
	localparam logic [RADIUS_W-1:0] RADIUS_TOP   = 4'd15;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;

	// Operation codes of the shared adder
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} cwm_alu_op_t;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_SUM   = 7'b0000100,
		ST_NEG   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_SIGN  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} cwm_state_t;

endpackage

// ===== rtl/cwm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cwm_alu.sv =====
// Shared add/subtract unit used for accumulation, negation and division steps.
`timescale 1ns / 1ps

module cwm_alu #(
	parameter int W = 22
) (
	input  cwm_pkg::cwm_alu_op_t op,
	input  logic [W-1:0]         a,
	input  logic [W-1:0]         b,
	output logic [W-1:0]         y
);

	// Select sum or difference
	always_comb begin
		case (op)
			cwm_pkg::ALU_ADD: y = a + b;
			cwm_pkg::ALU_SUB: y = a - b;
			default:          y = a + b;
		endcase
	end

endmodule

// ===== rtl/centered_window_mean_filter_top.sv =====
// Top level of the centered window mean filter: sequencer, datapath and history RAM.
`timescale 1ns / 1ps

// Centered moving-average filter over a stream of signed 16-bit samples with
// a last flag. Each result is the truncated-toward-zero mean of the samples
// within window_radius positions on each side (radius capped at MAX_RADIUS),
// clipped at both ends of the sequence. Result i leaves once sample i+radius
// has arrived; a sample with tlast flushes every pending result, and the last
// result carries tlast. The block handles one input transaction at a time:
// s_tready is high only while idle. An input that releases no result
// goes from the check state straight back to idle. Each result walks the n
// samples in the clipped window (one RAM read per sample through the single
// history read port), takes the magnitude, runs one restoring divide step per
// cycle in the shared adder for each of the SUM_W accumulator bits (SUM_W is
// 16 + log2 of the history depth, 21 at the default), restores the sign and
// then waits out any output stall. The history RAM needs no clearing pass.
module centered_window_mean_filter_top #(
	parameter int MAX_RADIUS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,  // window_radius
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // [15:0] sample
	input  logic        s_tlast,      // is_final
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,      // [15:0] window_mean
	output logic        m_tlast       // is_end
);

	localparam int SW     = cwm_pkg::SAMPLE_W;
	localparam int CW     = cwm_pkg::COUNT_W;
	localparam int RW     = cwm_pkg::RADIUS_W;
	localparam int ADDR_W = $clog2(2 * MAX_RADIUS + 2);
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SUM_W  = SW + ADDR_W;
	localparam int AW     = SUM_W + 1;
	localparam int DCNT_W = $clog2(SUM_W + 1);
	localparam logic [RW-1:0] R_CAP =
		(MAX_RADIUS > 15) ? cwm_pkg::RADIUS_TOP : RW'(MAX_RADIUS);

	cwm_pkg::cwm_state_t state_q;
	logic [RW-1:0]       radius_q;
	logic [CW-1:0]       recv_q;
	logic [CW-1:0]       emit_q;
	logic                fin_q;
	logic                taken_q;
	logic                end_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       hi_q;
	logic [ADDR_W-1:0]   n_q;
	logic [SUM_W-1:0]    sum_q;
	logic                neg_q;
	logic [SUM_W-1:0]    quo_q;
	logic [ADDR_W-1:0]   rem_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic                rd_vq;
	logic                m_tvalid_q;
	logic [SW-1:0]       m_tdata_q;
	logic                m_tlast_q;

	logic                in_hs;
	logic                out_hs;
	logic [RW-1:0]       r_eff;
	logic [CW:0]         emit_plus_r;
	logic [CW-1:0]       last_pos;
	logic                pend;
	logic [CW-1:0]       lo;
	logic [CW-1:0]       hi;
	logic [ADDR_W-1:0]   n;
	logic                rd_en;
	logic [SW-1:0]       rd_data;
	logic [ADDR_W:0]     rem2;
	cwm_pkg::cwm_alu_op_t alu_op;
	logic [AW-1:0]       alu_a;
	logic [AW-1:0]       alu_b;
	logic [AW-1:0]       alu_y;

	assign in_hs  = s_tvalid && s_tready;
	assign out_hs = m_tvalid_q && m_tready;

	// Window bounds for the next pending centre
	always_comb begin
		r_eff       = (radius_q > R_CAP) ? R_CAP : radius_q;
		emit_plus_r = {1'b0, emit_q} + (CW + 1)'(r_eff);
		last_pos    = recv_q - 1'b1;
		if (fin_q) begin
			pend = emit_q < recv_q;
		end else begin
			pend = taken_q && (emit_plus_r < {1'b0, recv_q});
		end
		lo = (emit_q >= CW'(r_eff)) ? emit_q - CW'(r_eff) : '0;
		hi = (emit_plus_r > {1'b0, last_pos}) ? last_pos : emit_plus_r[CW-1:0];
		n  = ADDR_W'(hi - lo + 1'b1);
	end

	assign rd_en = (state_q == cwm_pkg::ST_SUM) && (j_q <= hi_q);
	assign rem2  = {rem_q, quo_q[SUM_W-1]};

	// History RAM
	cwm_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (in_hs && (recv_q != cwm_pkg::COUNT_MAX)),
		.waddr(recv_q[ADDR_W-1:0]),
		.wdata(s_tdata),
		.re   (rd_en),
		.raddr(j_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Route operands to the shared adder
	always_comb begin
		case (state_q)
			cwm_pkg::ST_SUM: begin
				alu_op = cwm_pkg::ALU_ADD;
				alu_a  = {sum_q[SUM_W-1], sum_q};
				alu_b  = {{(AW - SW){rd_data[SW-1]}}, rd_data};
			end
			cwm_pkg::ST_NEG: begin
				alu_op = cwm_pkg::ALU_SUB;
				alu_a  = '0;
				alu_b  = {sum_q[SUM_W-1], sum_q};
			end
			cwm_pkg::ST_DIV: begin
				alu_op = cwm_pkg::ALU_SUB;
				alu_a  = {{(AW - ADDR_W - 1){1'b0}}, rem2};
				alu_b  = {{(AW - ADDR_W){1'b0}}, n_q};
			end
			cwm_pkg::ST_SIGN: begin
				alu_op = cwm_pkg::ALU_SUB;
				alu_a  = '0;
				alu_b  = {1'b0, quo_q};
			end
			default: begin
				alu_op = cwm_pkg::ALU_ADD;
				alu_a  = '0;
				alu_b  = '0;
			end
		endcase
	end

	cwm_alu #(
		.W(AW)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cwm_pkg::RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// Sequencer and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cwm_pkg::ST_IDLE;
			recv_q     <= '0;
			emit_q     <= '0;
			fin_q      <= 1'b0;
			taken_q    <= 1'b0;
			rd_vq      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				cwm_pkg::ST_IDLE: begin
					if (in_hs) begin
						fin_q   <= s_tlast;
						taken_q <= recv_q != cwm_pkg::COUNT_MAX;
						if (recv_q != cwm_pkg::COUNT_MAX) begin
							recv_q <= recv_q + 1'b1;
						end
						state_q <= cwm_pkg::ST_CHECK;
					end
				end
				cwm_pkg::ST_CHECK: begin
					rd_vq <= 1'b0;
					if (pend) begin
						state_q <= cwm_pkg::ST_SUM;
					end else begin
						if (fin_q) begin
							recv_q <= '0;
							emit_q <= '0;
						end
						state_q <= cwm_pkg::ST_IDLE;
					end
				end
				cwm_pkg::ST_SUM: begin
					rd_vq <= rd_en;
					if (!rd_en) begin
						state_q <= cwm_pkg::ST_NEG;
					end
				end
				cwm_pkg::ST_NEG: begin
					state_q <= cwm_pkg::ST_DIV;
				end
				cwm_pkg::ST_DIV: begin
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= cwm_pkg::ST_SIGN;
					end
				end
				cwm_pkg::ST_SIGN: begin
					m_tvalid_q <= 1'b1;
					state_q    <= cwm_pkg::ST_OUT;
				end
				cwm_pkg::ST_OUT: begin
					if (out_hs) begin
						m_tvalid_q <= 1'b0;
						emit_q     <= emit_q + 1'b1;
						state_q    <= cwm_pkg::ST_CHECK;
					end
				end
				default: begin
					state_q <= cwm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: window walk, magnitude, restoring divide, sign restore
	always_ff @(posedge clk) begin
		case (state_q)
			cwm_pkg::ST_CHECK: begin
				j_q   <= lo;
				hi_q  <= hi;
				n_q   <= n;
				sum_q <= '0;
				end_q <= fin_q && (emit_q == last_pos);
			end
			cwm_pkg::ST_SUM: begin
				if (rd_en) begin
					j_q <= j_q + 1'b1;
				end
				if (rd_vq) begin
					sum_q <= alu_y[SUM_W-1:0];
				end
			end
			cwm_pkg::ST_NEG: begin
				neg_q  <= sum_q[SUM_W-1];
				quo_q  <= sum_q[SUM_W-1] ? alu_y[SUM_W-1:0] : sum_q;
				rem_q  <= '0;
				dcnt_q <= DCNT_W'(SUM_W);
			end
			cwm_pkg::ST_DIV: begin
				dcnt_q <= dcnt_q - 1'b1;
				if (!alu_y[AW-1]) begin
					rem_q <= alu_y[ADDR_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2[ADDR_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end
			cwm_pkg::ST_SIGN: begin
				m_tdata_q <= neg_q ? alu_y[SW-1:0] : quo_q[SW-1:0];
				m_tlast_q <= end_q;
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == cwm_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/cwm_checker.sv =====
// Port-level checks for the centered window mean filter, bound to the top level.
`timescale 1ns / 1ps

module cwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed or dropped");

	// Never take input while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// Drop ready after an input transaction
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after input transaction");

	// Drop valid after an output transaction
	a_gap_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("valid stayed high after output transaction");

endmodule

bind centered_window_mean_filter_top cwm_checker u_cwm_checker (.*);
